### rtl/jos_pkg.sv
// jos_pkg: request/response types, operation and status codes and window
// constants for the jvm operand stack unit; no dependencies
package jos_pkg;

  typedef logic [31:0] slot_t;

  typedef enum logic [3:0] {
    OP_PUSH    = 4'd0,
    OP_POP     = 4'd1,
    OP_POP2    = 4'd2,
    OP_DUP     = 4'd3,
    OP_DUP_X1  = 4'd4,
    OP_DUP_X2  = 4'd5,
    OP_DUP2    = 4'd6,
    OP_DUP2_X1 = 4'd7,
    OP_DUP2_X2 = 4'd8,
    OP_SWAP    = 4'd9
  } op_e;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  // top-of-stack window held in flops, the rest lives in memory
  localparam int WIN       = 8;
  localparam int WIN_IDX_W = 3;
  localparam int WIN_CNT_W = 4;
  localparam int MAX_NEED  = 4;
  localparam int MAX_OUT   = 6;
  localparam logic [WIN_CNT_W-1:0] FILL_LOW  = 4'd4;
  localparam logic [WIN_CNT_W-1:0] SPILL_AT  = 4'd5;
  localparam logic [WIN_CNT_W-1:0] ROOM_MAX  = 4'd6;

  typedef struct packed {
    logic [3:0]  operation;
    logic [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic [31:0] top_value;
    logic [6:0]  depth;
    logic [1:0]  status;
  } rsp_t;

  // slots taken from the top, slots written back, outcome
  typedef struct packed {
    logic [2:0] need;
    logic [2:0] count;
    logic [1:0] status;
  } op_ctl_t;

endpackage

### rtl/jos_op_unit.sv
// jos_op_unit: decodes one stack operation, checks depth limits and builds
// the new top slots from the current top four or the pushed value; uses jos_pkg
module jos_op_unit #(
  parameter int STACK_DEPTH = 64,
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1)
) (
  input  jos_pkg::req_t                             req,
  input  logic [DEPTH_W-1:0]                        depth,
  input  jos_pkg::slot_t [jos_pkg::MAX_NEED-1:0]    top_slots,
  output jos_pkg::op_ctl_t                          ctl,
  output jos_pkg::slot_t [jos_pkg::MAX_OUT-1:0]     fresh
);

  localparam logic [DEPTH_W:0] LIMIT = (DEPTH_W + 1)'(STACK_DEPTH);

  logic [2:0]                          need;
  logic [2:0]                          count;
  logic [jos_pkg::MAX_OUT-1:0][1:0]    pick;
  logic                                is_push;
  logic [DEPTH_W:0]                    depth_ext;
  logic [DEPTH_W:0]                    after;

  // pick[j] names the old slot (0 = old top) that lands at position j from the top
  always_comb begin
    need  = 3'd0;
    count = 3'd0;
    pick  = '0;
    case (req.operation)
      jos_pkg::OP_POP:  need = 3'd1;
      jos_pkg::OP_POP2: need = 3'd2;
      jos_pkg::OP_DUP: begin
        need = 3'd1; count = 3'd2;
      end
      jos_pkg::OP_DUP_X1: begin
        need = 3'd2; count = 3'd3;
        pick[1] = 2'd1;
      end
      jos_pkg::OP_DUP_X2: begin
        need = 3'd3; count = 3'd4;
        pick[1] = 2'd1; pick[2] = 2'd2;
      end
      jos_pkg::OP_DUP2: begin
        need = 3'd2; count = 3'd4;
        pick[1] = 2'd1; pick[3] = 2'd1;
      end
      jos_pkg::OP_DUP2_X1: begin
        need = 3'd3; count = 3'd5;
        pick[1] = 2'd1; pick[2] = 2'd2; pick[4] = 2'd1;
      end
      jos_pkg::OP_DUP2_X2: begin
        need = 3'd4; count = 3'd6;
        pick[1] = 2'd1; pick[2] = 2'd2; pick[3] = 2'd3; pick[5] = 2'd1;
      end
      jos_pkg::OP_SWAP: begin
        need = 3'd2; count = 3'd2;
        pick[0] = 2'd1;
      end
      default: ;
    endcase
  end

  assign is_push   = (req.operation == jos_pkg::OP_PUSH);
  assign depth_ext = {1'b0, depth};
  assign after     = depth_ext + (DEPTH_W + 1)'(count) - (DEPTH_W + 1)'(need);

  always_comb begin
    ctl.need   = need;
    ctl.count  = count;
    ctl.status = jos_pkg::ST_OK;
    if (is_push) begin
      ctl.need  = 3'd0;
      ctl.count = 3'd1;
      if (depth_ext >= LIMIT) begin
        ctl.count  = 3'd0;
        ctl.status = jos_pkg::ST_OVERFLOW;
      end
    end else if (depth_ext < (DEPTH_W + 1)'(need)) begin
      ctl.need   = 3'd0;
      ctl.count  = 3'd0;
      ctl.status = jos_pkg::ST_UNDERFLOW;
    end else if (after > LIMIT) begin
      ctl.need   = 3'd0;
      ctl.count  = 3'd0;
      ctl.status = jos_pkg::ST_OVERFLOW;
    end
  end

  always_comb begin
    for (int j = 0; j < jos_pkg::MAX_OUT; j++) begin
      fresh[j] = top_slots[pick[j]];
    end
    if (is_push) begin
      fresh[0] = req.push_value;
    end
  end

endmodule

### rtl/jvm_operand_stack_ops.sv
// jvm_operand_stack_ops: jvm operand stack, one stack bytecode per request
// response is valid in the cycle after the request; one request per cycle while
// no fill is pending, the response is not stalled, the top window has at least four
// slots (or holds the whole stack) and room for two more; the window is refilled from
// memory a slot at a time by the single registered read port; spilling to memory runs
// alongside requests; reset clears depth, window counts and handshake state; memory
// contents need no clearing; uses jos_pkg and jos_op_unit
module jvm_operand_stack_ops #(
  parameter int STACK_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  jos_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output jos_pkg::rsp_t  rsp
);

  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int CW      = jos_pkg::WIN_CNT_W;

  jos_pkg::slot_t                             win [jos_pkg::WIN];
  jos_pkg::slot_t                             win_next [jos_pkg::WIN];
  logic [CW-1:0]                              wcnt;
  logic [CW-1:0]                              wcnt_next;
  logic [DEPTH_W-1:0]                         mcnt;
  logic [DEPTH_W-1:0]                         mcnt_next;
  logic [DEPTH_W-1:0]                         depth;
  logic [DEPTH_W-1:0]                         depth_next;
  logic                                       fill_pending;
  jos_pkg::slot_t                             mem [STACK_DEPTH];
  jos_pkg::slot_t                             rdata;

  jos_pkg::slot_t [jos_pkg::MAX_NEED-1:0]     top_slots;
  jos_pkg::slot_t [jos_pkg::MAX_OUT-1:0]      fresh;
  jos_pkg::op_ctl_t                           ctl;

  logic                                       out_free;
  logic                                       window_ready;
  logic                                       accept;
  logic                                       spill;
  logic                                       fill_issue;
  logic [CW-1:0]                              need_c;
  logic [CW-1:0]                              count_c;
  logic [jos_pkg::WIN_IDX_W-1:0]              spill_idx;
  logic [ADDR_W-1:0]                          spill_addr;
  logic [ADDR_W-1:0]                          fill_addr;

  always_comb begin
    for (int k = 0; k < jos_pkg::MAX_NEED; k++) begin
      top_slots[k] = win[k];
    end
  end

  jos_op_unit #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_op (
    .req       (req),
    .depth     (depth),
    .top_slots (top_slots),
    .ctl       (ctl),
    .fresh     (fresh)
  );

  assign out_free     = !rsp_valid || !rsp_stall;
  assign window_ready = !fill_pending
                        && (wcnt >= jos_pkg::FILL_LOW || mcnt == '0)
                        && (wcnt <= jos_pkg::ROOM_MAX);
  assign req_stall    = !(window_ready && out_free);
  assign accept       = req_valid && !req_stall;

  // the bottom window slot is never among the four an operation reads
  assign spill      = (wcnt >= jos_pkg::SPILL_AT);
  assign fill_issue = !fill_pending && (wcnt < jos_pkg::FILL_LOW) && (mcnt != '0);

  assign need_c     = accept ? CW'(ctl.need)  : '0;
  assign count_c    = accept ? CW'(ctl.count) : '0;
  assign spill_idx  = jos_pkg::WIN_IDX_W'(wcnt - CW'(1));
  assign spill_addr = mcnt[ADDR_W-1:0];
  assign fill_addr  = ADDR_W'(mcnt - DEPTH_W'(1));

  always_comb begin
    logic [CW:0] src;
    for (int j = 0; j < jos_pkg::WIN; j++) begin
      src = (CW + 1)'(j) + (CW + 1)'(need_c) - (CW + 1)'(count_c);
      if (CW'(j) < count_c) begin
        win_next[j] = fresh[j];
      end else if (src < (CW + 1)'(jos_pkg::WIN)) begin
        win_next[j] = win[src[jos_pkg::WIN_IDX_W-1:0]];
      end else begin
        win_next[j] = win[j];
      end
    end
    if (fill_pending) begin
      win_next[wcnt[jos_pkg::WIN_IDX_W-1:0]] = rdata;
    end
  end

  assign wcnt_next  = wcnt + count_c - need_c - CW'(spill) + CW'(fill_pending);
  assign mcnt_next  = mcnt + DEPTH_W'(spill) - DEPTH_W'(fill_issue);
  assign depth_next = depth + DEPTH_W'(count_c) - DEPTH_W'(need_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt         <= '0;
      mcnt         <= '0;
      depth        <= '0;
      fill_pending <= 1'b0;
    end else begin
      wcnt         <= wcnt_next;
      mcnt         <= mcnt_next;
      depth        <= depth_next;
      fill_pending <= fill_issue;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < jos_pkg::WIN; j++) begin
      win[j] <= win_next[j];
    end
  end

  // spill writes and fill reads of the lower stack
  always_ff @(posedge clk) begin
    if (spill) begin
      mem[spill_addr] <= win[spill_idx];
    end
    if (fill_issue) begin
      rdata <= mem[fill_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.top_value <= (depth_next != '0) ? win_next[0] : '0;
      rsp.depth     <= 7'(depth_next);
      rsp.status    <= ctl.status;
    end
  end

endmodule

### test/jos_checker.sv
`timescale 1ns / 1ps
// jos_checker: watches the request and response channels of jvm_operand_stack_ops,
// keeps its own operand stack and compares every response with the predicted one
// depends on jos_pkg
module jos_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  jos_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  jos_pkg::rsp_t rsp,
  output int            mismatches,
  output int            pending
);

  jos_pkg::slot_t model_slots [STACK_DEPTH];
  int unsigned    model_sp;
  jos_pkg::rsp_t  expected_rsp_q [$];

  task automatic apply_stack_op(input jos_pkg::req_t r, output jos_pkg::rsp_t e);
    jos_pkg::slot_t taken [jos_pkg::MAX_NEED];
    int             pick [jos_pkg::MAX_OUT];
    int unsigned    need;
    int unsigned    count;
    int unsigned    base;
    logic [1:0]     st;
    need  = 0;
    count = 0;
    pick  = '{0, 0, 0, 0, 0, 0};
    st    = jos_pkg::ST_OK;
    if (r.operation == jos_pkg::OP_PUSH) begin
      if (model_sp >= STACK_DEPTH) begin
        st = jos_pkg::ST_OVERFLOW;
      end else begin
        model_slots[model_sp] = r.push_value;
        model_sp++;
      end
    end else begin
      // unused codes keep need and count at zero and leave the stack alone
      case (r.operation)
        jos_pkg::OP_POP:     begin need = 1; count = 0; end
        jos_pkg::OP_POP2:    begin need = 2; count = 0; end
        jos_pkg::OP_DUP:     begin need = 1; count = 2; pick = '{0, 0, 0, 0, 0, 0}; end
        jos_pkg::OP_DUP_X1:  begin need = 2; count = 3; pick = '{0, 1, 0, 0, 0, 0}; end
        jos_pkg::OP_DUP_X2:  begin need = 3; count = 4; pick = '{0, 2, 1, 0, 0, 0}; end
        jos_pkg::OP_DUP2:    begin need = 2; count = 4; pick = '{1, 0, 1, 0, 0, 0}; end
        jos_pkg::OP_DUP2_X1: begin need = 3; count = 5; pick = '{1, 0, 2, 1, 0, 0}; end
        jos_pkg::OP_DUP2_X2: begin need = 4; count = 6; pick = '{1, 0, 3, 2, 1, 0}; end
        jos_pkg::OP_SWAP:    begin need = 2; count = 2; pick = '{0, 1, 0, 0, 0, 0}; end
        default:             begin need = 0; count = 0; end
      endcase
      if (model_sp < need) begin
        st = jos_pkg::ST_UNDERFLOW;
      end else if (model_sp - need + count > STACK_DEPTH) begin
        st = jos_pkg::ST_OVERFLOW;
      end else begin
        // pick index 0 is the old top
        for (int i = 0; i < need; i++) taken[i] = model_slots[model_sp - 1 - i];
        base = model_sp - need;
        for (int i = 0; i < count; i++) model_slots[base + i] = taken[pick[i]];
        model_sp = base + count;
      end
    end
    e.top_value = (model_sp > 0) ? model_slots[model_sp - 1] : '0;
    e.depth     = 7'(model_sp);
    e.status    = st;
  endtask

  always @(posedge clk) begin
    jos_pkg::rsp_t predicted;
    if (rst) begin
      model_sp   = 0;
      mismatches = 0;
      expected_rsp_q.delete();
    end else begin
      if (req_valid && !req_stall) begin
        apply_stack_op(req, predicted);
        expected_rsp_q.push_back(predicted);
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected response top %h depth %0d status %0d",
                     $time, rsp.top_value, rsp.depth, rsp.status);
          mismatches++;
        end else begin
          predicted = expected_rsp_q.pop_front();
          if (rsp.top_value !== predicted.top_value || rsp.depth !== predicted.depth ||
              rsp.status !== predicted.status) begin
            if (mismatches < 10)
              $display(
                "%0t: mismatch expected top %h depth %0d status %0d, got top %h depth %0d status %0d",
                $time, predicted.top_value, predicted.depth, predicted.status,
                rsp.top_value, rsp.depth, rsp.status);
            mismatches++;
          end
        end
      end
    end
    pending = expected_rsp_q.size();
  end

endmodule

### test/tb_jvm_operand_stack_ops.sv
`timescale 1ns / 1ps
// tb_jvm_operand_stack_ops: drives stack requests with random idling and stalls,
// runs a cycle watchdog and gives the verdict
// depends on jos_pkg, jvm_operand_stack_ops and jos_checker
module tb_jvm_operand_stack_ops;

  localparam int STACK_DEPTH      = 64;
  localparam int RANDOM_PER_PHASE = 476;
  localparam int WATCHDOG_LIMIT   = 1000;
  localparam int DRAIN_CYCLES     = 16;
  localparam logic [3:0] OP_UNUSED_LO = 4'd10;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  typedef enum int {BIAS_PUSH, BIAS_POP, BIAS_MIXED} bias_e;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  jos_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  jos_pkg::rsp_t rsp;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;
  int mismatches;
  int pending;

  jvm_operand_stack_ops #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  jos_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  task automatic send_request(input logic [3:0] op, input jos_pkg::slot_t value);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{operation: op, push_value: value};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic jos_pkg::slot_t pick_slot_value();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return jos_pkg::slot_t'(1) << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] pick_operation(bias_e bias);
    int roll;
    int push_pct;
    roll     = $urandom_range(99);
    push_pct = (bias == BIAS_PUSH) ? 70 : (bias == BIAS_POP) ? 15 : 35;
    if (roll < 3) return 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    if (roll < 3 + push_pct) return jos_pkg::OP_PUSH;
    if (bias == BIAS_POP && roll < 3 + push_pct + 45)
      return roll[0] ? jos_pkg::OP_POP : jos_pkg::OP_POP2;
    return 4'($urandom_range(jos_pkg::OP_SWAP, jos_pkg::OP_POP));
  endfunction

  // runs of push-heavy, pop-heavy and mixed requests drive the depth up and down
  task automatic run_random_phase(input int items);
    int    left;
    int    run_len;
    bias_e bias;
    left = items;
    while (left > 0) begin
      bias    = bias_e'($urandom_range(2));
      run_len = $urandom_range(120, 40);
      for (int i = 0; i < run_len && left > 0; i++) begin
        send_request(pick_operation(bias), pick_slot_value());
        left--;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    idle_pct  = 37;
    stall_pct = 60;
    // empty stack: underflow on every consuming operation; short stacks follow, then every operation
    send_request(jos_pkg::OP_POP, 32'h1234_5678);
    send_request(jos_pkg::OP_POP2, '0);
    send_request(jos_pkg::OP_DUP, '0);
    send_request(jos_pkg::OP_SWAP, '1);
    send_request(OP_UNUSED_HI, '1);
    send_request(jos_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_request(jos_pkg::OP_DUP_X1, '0);
    send_request(jos_pkg::OP_PUSH, 32'h0000_0000);
    send_request(jos_pkg::OP_DUP_X2, '0);
    send_request(jos_pkg::OP_PUSH, 32'h8000_0001);
    send_request(jos_pkg::OP_DUP2_X2, '0);
    send_request(jos_pkg::OP_PUSH, 32'h7FFF_FFFE);
    send_request(jos_pkg::OP_DUP, '1);
    send_request(jos_pkg::OP_DUP_X1, '0);
    send_request(jos_pkg::OP_DUP_X2, '0);
    send_request(jos_pkg::OP_DUP2, '0);
    send_request(jos_pkg::OP_DUP2_X1, '0);
    send_request(jos_pkg::OP_DUP2_X2, '0);
    send_request(jos_pkg::OP_SWAP, '0);
    send_request(jos_pkg::OP_POP2, '0);
    send_request(jos_pkg::OP_POP, '0);
    send_request(OP_UNUSED_LO, 32'hA5A5_5A5A);
    run_random_phase(RANDOM_PER_PHASE);

    idle_pct  = 60;
    stall_pct = 37;
    run_random_phase(RANDOM_PER_PHASE);

    idle_pct  = 0;
    stall_pct = 0;
    run_random_phase(RANDOM_PER_PHASE);

    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### jvm_operand_stack_ops.f
rtl/jos_pkg.sv
rtl/jos_op_unit.sv
rtl/jvm_operand_stack_ops.sv
test/jos_checker.sv
test/tb_jvm_operand_stack_ops.sv
